[rtl/separable_gaussian_blur_unit_assert.svh]
// assertion macros for the blur unit checkers
`ifndef SEPARABLE_GAUSSIAN_BLUR_UNIT_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_UNIT_ASSERT_SVH

// clocked assertion, disabled while reset is asserted
`define SGB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sgb assertion failed");

// clocked assertion that also holds during reset
`define SGB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sgb assertion failed");

`endif

[rtl/sgb_pkg.sv]
// ----------------------------------------------------------------------------
// sgb_pkg
// shared constants, types and helpers of the separable blur unit
// ----------------------------------------------------------------------------
package sgb_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN         = 2 * MAX_RADIUS + 1;
    localparam int COL_BITS    = 10;
    localparam int ROW_BITS    = 12;
    localparam int RAD_BITS    = 3;
    localparam int K_BITS      = 5;
    localparam int WIN_BITS    = 4;
    localparam int RAM_DEPTH   = WIN * MAX_WIDTH;
    localparam int RAM_ABITS   = $clog2(RAM_DEPTH);
    localparam int ACC_BITS    = 36;
    localparam int ADDR_BITS   = 6;
    localparam int DATA_BITS   = 64;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_RADIUS  = 3'd2;
    localparam logic [2:0] REG_COEF_LO = 3'd3;
    localparam logic [2:0] REG_COEF_HI = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic PH_ACCEPT = 1'b0;
    localparam logic PH_DRAIN  = 1'b1;

    typedef struct packed {
        logic [COL_BITS-1:0] wl;
        logic [ROW_BITS-1:0] hl;
        logic [RAD_BITS-1:0] rad;
        logic [63:0]         coef_lo;
        logic [63:0]         coef_hi;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctl;

    // residue mod 15 by folding hex digits
    function automatic logic [WIN_BITS-1:0] mod15(input logic [ROW_BITS-1:0] v);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = {2'b00, v[3:0]} + {2'b00, v[7:4]} + {2'b00, v[11:8]};
        s2 = {1'b0, s1[3:0]} + {3'b000, s1[5:4]};
        if (s2 >= 5'd15) begin
            s2 = s2 - 5'd15;
        end
        return s2[WIN_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] coef_sel(input t_cfg cfg,
                                                        input logic [RAD_BITS-1:0] k);
        logic [63:0] w;
        w = k[2] ? cfg.coef_hi : cfg.coef_lo;
        return w[{k[1:0], 4'b0000} +: SAMPLE_BITS];
    endfunction

endpackage

[rtl/sgb_if.sv]
// ----------------------------------------------------------------------------
// sgb_if
// request channels of the blur unit: input samples and blurred results
// ----------------------------------------------------------------------------
interface sgb_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] sample;
    modport source (output valid, opcode, sample, input ready);
    modport sink   (input valid, opcode, sample, output ready);
endinterface

interface sgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] filtered_sample;
    logic [9:0]  out_column;
    logic [11:0] out_row;
    logic        last_of_run;
    logic        frame_end;
    modport source (output valid, filtered_sample, out_column, out_row, last_of_run,
                    frame_end, input ready);
    modport sink   (input valid, filtered_sample, out_column, out_row, last_of_run,
                    frame_end, output ready);
endinterface

[rtl/sgb_ram.sv]
// ----------------------------------------------------------------------------
// sgb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module sgb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sgb_cfg.sv]
// ----------------------------------------------------------------------------
// sgb_cfg
// apb register file, gives clamped image size, radius and coefficients
// ----------------------------------------------------------------------------
module sgb_cfg import sgb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [2:0]  r_rad;
    logic [63:0] r_lo;
    logic [63:0] r_hi;
    logic        wr;
    logic [2:0]  idx;
    logic [10:0] wl;
    logic [12:0] hl;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1;
            r_height <= 13'd1;
            r_rad    <= 3'd0;
            r_lo     <= 64'h8000;
            r_hi     <= 64'h0;
        end else if (wr) begin
            case (idx)
                REG_WIDTH:   r_width  <= pwdata[10:0];
                REG_HEIGHT:  r_height <= pwdata[12:0];
                REG_RADIUS:  r_rad    <= pwdata[2:0];
                REG_COEF_LO: r_lo     <= pwdata;
                REG_COEF_HI: r_hi     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH:   prdata = {53'b0, r_width};
            REG_HEIGHT:  prdata = {51'b0, r_height};
            REG_RADIUS:  prdata = {61'b0, r_rad};
            REG_COEF_LO: prdata = r_lo;
            REG_COEF_HI: prdata = r_hi;
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == 11'd0) begin
            wl = 11'd0;
        end else if (r_width > 11'd1024) begin
            wl = 11'd1023;
        end else begin
            wl = r_width - 11'd1;
        end
        if (r_height == 13'd0) begin
            hl = 13'd0;
        end else if (r_height > 13'd4096) begin
            hl = 13'd4095;
        end else begin
            hl = r_height - 13'd1;
        end
    end

    assign pready        = 1'b1;
    assign o_cfg.wl      = wl[COL_BITS-1:0];
    assign o_cfg.hl      = hl[ROW_BITS-1:0];
    assign o_cfg.rad     = r_rad;
    assign o_cfg.coef_lo = r_lo;
    assign o_cfg.coef_hi = r_hi;

endmodule

[rtl/sgb_mac.sv]
// ----------------------------------------------------------------------------
// sgb_mac
// shared multiply-accumulate with round to nearest and saturation
// ----------------------------------------------------------------------------
module sgb_mac import sgb_pkg::*; (
    input  logic                   i_clk,
    input  t_mac_ctl               i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_a,
    input  logic [SAMPLE_BITS-1:0] i_b,
    output logic [SAMPLE_BITS-1:0] o_res
);

    logic [ACC_BITS-1:0]      r_acc;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [ACC_BITS:0]        rsum;
    logic [ACC_BITS-15:0]     shifted;

    assign prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.en) begin
            r_acc <= r_acc + {{(ACC_BITS-2*SAMPLE_BITS){1'b0}}, prod};
        end
    end

    assign rsum    = {1'b0, r_acc} + (ACC_BITS+1)'(16384);
    assign shifted = rsum[ACC_BITS:15];
    assign o_res   = (|shifted[ACC_BITS-15:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
                                                         : shifted[SAMPLE_BITS-1:0];

endmodule

[rtl/separable_gaussian_blur_unit.sv]
// a pixel item is accepted, then each completed column runs its horizontal taps
// into the line store and, when its row is emitted, its vertical taps and an emit;
// a drain item runs vertical taps and an emit; a row end completes up to r+1 columns
// throughput: one item at a time, every tap goes through the single shared mac,
// and an emit waits while the previous result is held by the receiver
// reset: synchronous active low, clears positions, phase and output valid; no store clear
// ----------------------------------------------------------------------------
// separable_gaussian_blur_unit
// streamed separable gaussian blur with clamp to edge and line store
// ----------------------------------------------------------------------------
module separable_gaussian_blur_unit import sgb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgb_in_if.sink               i_pix,
    sgb_out_if.source            o_res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HORZ = 3'd1;
    localparam logic [2:0] S_HWR  = 3'd2;
    localparam logic [2:0] S_VERT = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    t_cfg     cfg;
    t_mac_ctl mac_ctl;

    logic [2:0]             r_state, n_state;
    logic [COL_BITS-1:0]    r_c, n_c, r_x, n_x, r_x1, n_x1;
    logic [ROW_BITS-1:0]    r_j, n_j, r_e, n_e, r_jmax, n_jmax;
    logic                   r_emit, n_emit, r_fend_row, n_fend_row;
    logic signed [K_BITS-1:0] r_k, n_k;
    logic                   r_pend, n_pend;
    logic [SAMPLE_BITS-1:0] r_pcoef, n_pcoef;
    logic [COL_BITS-1:0]    r_in_col, n_in_col, r_dr_col, n_dr_col;
    logic [ROW_BITS-1:0]    r_in_row, n_in_row, r_dr_row, n_dr_row;
    logic                   r_phase, n_phase;
    logic [SAMPLE_BITS-1:0] r_tap [WIN];

    logic                   r_o_vld;
    logic [SAMPLE_BITS-1:0] r_o_val;
    logic [COL_BITS-1:0]    r_o_col;
    logic [ROW_BITS-1:0]    r_o_row;
    logic                   r_o_last, r_o_fend;

    logic                   accept, tap_we, emit_go;
    logic [COL_BITS-1:0]    a_c, a_x0, a_x1, d_x;
    logic [ROW_BITS-1:0]    a_j, a_e, d_y, rad_row;
    logic signed [COL_BITS+1:0] a_cr, h_sum;
    logic                   a_row_end, a_cols, a_emit;
    logic [COL_BITS-1:0]    h_sx;
    logic signed [ROW_BITS+1:0] v_sum;
    logic [ROW_BITS-1:0]    v_sy;
    logic signed [K_BITS-1:0] rad_k, k_neg;
    logic [RAD_BITS-1:0]    k_abs;
    logic                   k_last, k_over;
    logic [RAM_ABITS-1:0]   ram_addr;
    logic                   ram_we;
    logic [SAMPLE_BITS-1:0] ram_rdata, mac_a, mac_b, mac_res;

    sgb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_pix.ready = (r_state == S_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;
    assign rad_row     = {{(ROW_BITS-RAD_BITS){1'b0}}, cfg.rad};
    assign rad_k       = $signed({{(K_BITS-RAD_BITS){1'b0}}, cfg.rad});
    assign k_neg       = -rad_k;

    // item setup
    always_comb begin
        a_c       = (r_in_col > cfg.wl) ? cfg.wl : r_in_col;
        a_j       = (r_in_row > cfg.hl) ? cfg.hl : r_in_row;
        a_cr      = $signed({2'b00, a_c}) - $signed({{(COL_BITS-1){1'b0}}, cfg.rad});
        a_row_end = (a_c == cfg.wl);
        a_cols    = a_row_end || !a_cr[COL_BITS+1];
        a_x0      = (a_row_end && a_cr[COL_BITS+1]) ? '0 : a_cr[COL_BITS-1:0];
        a_x1      = a_row_end ? a_c : a_cr[COL_BITS-1:0];
        a_emit    = (a_j >= rad_row) || (a_j == cfg.hl);
        a_e       = (a_j >= rad_row) ? a_j - rad_row : '0;
        d_x       = (r_dr_col > cfg.wl) ? cfg.wl : r_dr_col;
        d_y       = (r_dr_row > cfg.hl) ? cfg.hl : r_dr_row;
    end

    // tap addressing
    always_comb begin
        k_abs  = r_k[K_BITS-1] ? RAD_BITS'(-r_k) : r_k[RAD_BITS-1:0];
        k_last = (r_k == rad_k);
        k_over = (r_k > rad_k);
        h_sum  = $signed({2'b00, r_x}) + {{(COL_BITS+2-K_BITS){r_k[K_BITS-1]}}, r_k};
        if (h_sum[COL_BITS+1]) begin
            h_sx = '0;
        end else if (h_sum > $signed({2'b00, r_c})) begin
            h_sx = r_c;
        end else begin
            h_sx = h_sum[COL_BITS-1:0];
        end
        v_sum = $signed({2'b00, r_e}) + {{(ROW_BITS+2-K_BITS){r_k[K_BITS-1]}}, r_k};
        if (v_sum[ROW_BITS+1]) begin
            v_sy = '0;
        end else if (v_sum > $signed({2'b00, r_jmax})) begin
            v_sy = r_jmax;
        end else begin
            v_sy = v_sum[ROW_BITS-1:0];
        end
    end

    assign ram_we   = (r_state == S_HWR);
    assign ram_addr = ram_we ? {mod15(r_j), r_x} : {mod15(v_sy), r_x};

    sgb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (mac_res),
        .o_rdata (ram_rdata)
    );

    assign mac_a = (r_state == S_HORZ) ? r_tap[mod15({2'b00, h_sx})] : ram_rdata;
    assign mac_b = (r_state == S_HORZ) ? coef_sel(cfg, k_abs) : r_pcoef;

    sgb_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_res (mac_res)
    );

    assign emit_go = (r_state == S_EMIT) && (!r_o_vld || o_res.ready);
    assign tap_we  = accept && (i_pix.opcode == OP_PIXEL) && (r_phase == PH_ACCEPT);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_x        = r_x;
        n_x1       = r_x1;
        n_j        = r_j;
        n_e        = r_e;
        n_jmax     = r_jmax;
        n_emit     = r_emit;
        n_fend_row = r_fend_row;
        n_k        = r_k;
        n_pend     = 1'b0;
        n_pcoef    = r_pcoef;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_dr_col   = r_dr_col;
        n_dr_row   = r_dr_row;
        n_phase    = r_phase;
        mac_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                if (tap_we) begin
                    n_c        = a_c;
                    n_j        = a_j;
                    n_jmax     = a_j;
                    n_e        = a_e;
                    n_x        = a_x0;
                    n_x1       = a_x1;
                    n_emit     = a_emit;
                    n_fend_row = a_row_end && (a_j == cfg.hl) && (a_e == cfg.hl);
                    n_k        = k_neg;
                    mac_ctl.clr = 1'b1;
                    if (a_cols) begin
                        n_state = S_HORZ;
                    end
                    if (a_row_end) begin
                        n_in_col = '0;
                        if (a_j == cfg.hl) begin
                            n_in_row = '0;
                            if (a_e < cfg.hl) begin
                                n_phase  = PH_DRAIN;
                                n_dr_row = a_e + 1'b1;
                                n_dr_col = '0;
                            end
                        end else begin
                            n_in_row = a_j + 1'b1;
                        end
                    end else begin
                        n_in_col = a_c + 1'b1;
                    end
                end else if (accept && (i_pix.opcode == OP_DRAIN) &&
                             (r_phase == PH_DRAIN)) begin
                    n_x        = d_x;
                    n_x1       = d_x;
                    n_e        = d_y;
                    n_jmax     = cfg.hl;
                    n_fend_row = (d_y == cfg.hl);
                    n_k        = k_neg;
                    mac_ctl.clr = 1'b1;
                    n_state    = S_VERT;
                    if (d_x == cfg.wl) begin
                        n_dr_col = '0;
                        if (d_y == cfg.hl) begin
                            n_dr_row = '0;
                            n_phase  = PH_ACCEPT;
                        end else begin
                            n_dr_row = d_y + 1'b1;
                        end
                    end else begin
                        n_dr_col = d_x + 1'b1;
                    end
                end
            end
            S_HORZ: begin
                mac_ctl.en = 1'b1;
                n_k        = r_k + $signed(K_BITS'(1));
                if (k_last) begin
                    n_state = S_HWR;
                end
            end
            S_HWR: begin
                mac_ctl.clr = 1'b1;
                n_k         = k_neg;
                if (r_emit) begin
                    n_state = S_VERT;
                end else if (r_x == r_x1) begin
                    n_state = S_IDLE;
                end else begin
                    n_x     = r_x + 1'b1;
                    n_state = S_HORZ;
                end
            end
            S_VERT: begin
                mac_ctl.en = r_pend;
                if (!k_over) begin
                    n_pend  = 1'b1;
                    n_pcoef = coef_sel(cfg, k_abs);
                    n_k     = r_k + $signed(K_BITS'(1));
                end else if (!r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_go) begin
                    mac_ctl.clr = 1'b1;
                    n_k         = k_neg;
                    if (r_x == r_x1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_x     = r_x + 1'b1;
                        n_state = S_HORZ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_col <= '0;
            r_in_row <= '0;
            r_dr_col <= '0;
            r_dr_row <= '0;
            r_phase  <= PH_ACCEPT;
            r_pend   <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_dr_col <= n_dr_col;
            r_dr_row <= n_dr_row;
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            if (emit_go) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_x        <= n_x;
        r_x1       <= n_x1;
        r_j        <= n_j;
        r_e        <= n_e;
        r_jmax     <= n_jmax;
        r_emit     <= n_emit;
        r_fend_row <= n_fend_row;
        r_k        <= n_k;
        r_pcoef    <= n_pcoef;
        if (tap_we) begin
            r_tap[mod15({2'b00, a_c})] <= i_pix.sample;
        end
        if (emit_go) begin
            r_o_val  <= mac_res;
            r_o_col  <= r_x;
            r_o_row  <= r_e;
            r_o_last <= (r_x == r_x1);
            r_o_fend <= r_fend_row && (r_x == cfg.wl);
        end
    end

    assign o_res.valid           = r_o_vld;
    assign o_res.filtered_sample = r_o_val;
    assign o_res.out_column      = r_o_col;
    assign o_res.out_row         = r_o_row;
    assign o_res.last_of_run     = r_o_last;
    assign o_res.frame_end       = r_o_fend;

endmodule

[rtl/sgb_checker.sv]
// ----------------------------------------------------------------------------
// sgb_checker
// port level checks of the blur unit, attached by bind
// ----------------------------------------------------------------------------
`include "separable_gaussian_blur_unit_assert.svh"

module sgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_sample,
    input logic [9:0]  i_out_column,
    input logic [11:0] i_out_row,
    input logic        i_out_last,
    input logic        i_out_fend,
    input logic        i_pready
);

    // a stalled result holds
    `SGB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_out_sample, i_out_column, i_out_row, i_out_last, i_out_fend}))

    // the image end closes the request run
    `SGB_ASSERT(a_fend_last, i_clk, i_rst_n, i_out_valid && i_out_fend |-> i_out_last)

    // reset drops any pending result
    `SGB_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid)

    // the register port never waits
    `SGB_ASSERT_ALWAYS(a_pready, i_clk, i_pready)

endmodule

bind separable_gaussian_blur_unit sgb_checker u_sgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_sample (o_res.filtered_sample),
    .i_out_column (o_res.out_column),
    .i_out_row    (o_res.out_row),
    .i_out_last   (o_res.last_of_run),
    .i_out_fend   (o_res.frame_end),
    .i_pready     (pready)
);

[dv/tb_separable_gaussian_blur_unit.sv]
// ----------------------------------------------------------------------------
// tb_separable_gaussian_blur_unit
// self-checking bench: a blur model predicts every result of each request,
// directed frames first (reset values, saturation, size limits, mid-frame
// size changes), then random small frames with stray requests and stalls
// ----------------------------------------------------------------------------
module tb_separable_gaussian_blur_unit import sgb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [15:0] smp;
    } t_pix_req;

    typedef struct {
        logic [15:0] val;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
        logic        fend;
    } t_blur_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    sgb_in_if  pix_ch();
    sgb_out_if res_ch();

    separable_gaussian_blur_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_pix_req    pend_q[$];
    t_blur_res   blur_q[$];
    int          err_cnt = 0;
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 9;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;

    // blur model state
    logic [10:0] m_width = 11'd1;
    logic [12:0] m_rows = 13'd1;
    logic [2:0]  m_radius = 3'd0;
    logic [63:0] m_coef_lo = 64'h8000;
    logic [63:0] m_coef_hi = 64'h0;
    logic [15:0] tap_win [WIN];
    logic [15:0] line_mem [WIN*MAX_WIDTH];
    int          col_in = 0, row_in = 0, col_dr = 0, row_dr = 0;
    bit          draining = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int eff_width();
        if (m_width == 0) return 1;
        return (m_width > MAX_WIDTH) ? MAX_WIDTH : int'(m_width);
    endfunction

    function automatic int eff_height();
        if (m_rows == 0) return 1;
        return (m_rows > 4096) ? 4096 : int'(m_rows);
    endfunction

    function automatic longint unsigned tap_coef(int k);
        if (k < 0) k = -k;
        if (k < 4) return m_coef_lo[16*k +: 16];
        if (k < 8) return m_coef_hi[16*(k-4) +: 16];
        return 0;
    endfunction

    function automatic logic [15:0] round_sat(longint unsigned acc);
        longint unsigned v;
        v = (acc + 16384) >> 15;
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [15:0] horiz_sum(int x, int c, int r);
        longint unsigned acc;
        acc = 0;
        for (int k = -r; k <= r; k++) begin
            acc += longint'(tap_win[clip(x + k, 0, c) % WIN]) * tap_coef(k);
        end
        return round_sat(acc);
    endfunction

    function automatic logic [15:0] vert_sum(int x, int y, int hmax, int r);
        longint unsigned acc;
        acc = 0;
        for (int k = -r; k <= r; k++) begin
            acc += longint'(line_mem[(clip(y + k, 0, hmax) % WIN) * MAX_WIDTH + x])
                   * tap_coef(k);
        end
        return round_sat(acc);
    endfunction

    function automatic void push_blur(logic [15:0] v, int x, int y, bit fe);
        t_blur_res b;
        b.val = v;
        b.col = x[9:0];
        b.row = y[11:0];
        b.last = 1'b0;
        b.fend = fe;
        blur_q.insert(blur_q.size(), b);
    endfunction

    function automatic void blur_step(logic op, logic [15:0] smp);
        int wl, hl, r, c, j, x, y, x0, x1, e, n0;
        bit emit;
        wl = eff_width() - 1;
        hl = eff_height() - 1;
        r = m_radius;
        n0 = blur_q.size();
        if (op == OP_PIXEL) begin
            if (draining) return;
            c = (col_in > wl) ? wl : col_in;
            j = (row_in > hl) ? hl : row_in;
            tap_win[c % WIN] = smp;
            if (c < wl) begin
                x0 = c - r;
                x1 = c - r;
            end else begin
                x0 = (c - r < 0) ? 0 : c - r;
                x1 = c;
            end
            emit = (j >= r) || (j == hl);
            e = (j >= r) ? j - r : 0;
            for (x = x0; x >= 0 && x <= x1; x++) begin
                line_mem[(j % WIN) * MAX_WIDTH + x] = horiz_sum(x, c, r);
                if (emit) begin
                    push_blur(vert_sum(x, e, j, r), x, e,
                              c == wl && j == hl && x == wl && e == hl);
                end
            end
            if (c == wl) begin
                col_in = 0;
                if (j == hl) begin
                    row_in = 0;
                    if (e < hl) begin
                        draining = 1'b1;
                        row_dr = e + 1;
                        col_dr = 0;
                    end
                end else begin
                    row_in = j + 1;
                end
            end else begin
                col_in = c + 1;
            end
        end else begin
            if (!draining) return;
            x = (col_dr > wl) ? wl : col_dr;
            y = (row_dr > hl) ? hl : row_dr;
            push_blur(vert_sum(x, y, hl, r), x, y, x == wl && y == hl);
            if (x == wl) begin
                col_dr = 0;
                if (y == hl) begin
                    row_dr = 0;
                    draining = 1'b0;
                end else begin
                    row_dr = y + 1;
                end
            end else begin
                col_dr = x + 1;
            end
        end
        if (blur_q.size() > n0) blur_q[$].last = 1'b1;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else if (!pix_ch.valid || pix_ch.ready) begin
            if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                pix_ch.valid <= 1'b1;
                pix_ch.opcode <= pend_q[0].op;
                pix_ch.sample <= pend_q[0].smp;
                void'(pend_q.pop_front());
            end else begin
                pix_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req && rx_hold_left == 0) begin
            rx_hold_left <= 600;
        end else if (rx_hold_left > 1) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_left == 1 && !rx_hold_req) begin
            rx_hold_left <= 0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= (rx_hold_left <= 1) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_blur_res b;
        if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
            blur_step(pix_ch.opcode, pix_ch.sample);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (blur_q.size() == 0) begin
                flag_mismatch("unexpected result row", res_ch.out_row, 0);
            end else begin
                b = blur_q.pop_front();
                if (res_ch.filtered_sample !== b.val)
                    flag_mismatch("filtered_sample", res_ch.filtered_sample, b.val);
                if (res_ch.out_column !== b.col)
                    flag_mismatch("out_column", res_ch.out_column, b.col);
                if (res_ch.out_row !== b.row)
                    flag_mismatch("out_row", res_ch.out_row, b.row);
                if (res_ch.last_of_run !== b.last)
                    flag_mismatch("last_of_run", res_ch.last_of_run, b.last);
                if (res_ch.frame_end !== b.fend)
                    flag_mismatch("frame_end", res_ch.frame_end, b.fend);
            end
        end
    end

    task automatic wait_idle();
        while (pend_q.size() > 0 || pix_ch.valid || blur_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:   m_width = val[10:0];
            REG_HEIGHT:  m_rows = val[12:0];
            REG_RADIUS:  m_radius = val[2:0];
            REG_COEF_LO: m_coef_lo = val;
            REG_COEF_HI: m_coef_hi = val;
            default: ;
        endcase
    endtask

    task automatic configure(int w, int h, int r, logic [63:0] lo, logic [63:0] hi);
        wait_idle();
        reg_write(REG_WIDTH, 64'(w));
        reg_write(REG_HEIGHT, 64'(h));
        reg_write(REG_RADIUS, 64'(r));
        reg_write(REG_COEF_LO, lo);
        reg_write(REG_COEF_HI, hi);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void queue_req(logic op, logic [15:0] smp);
        t_pix_req p;
        p.op = op;
        p.smp = smp;
        pend_q.insert(pend_q.size(), p);
    endfunction

    // one full frame of pixels then the drains it needs, with optional stray requests
    function automatic int queue_frame(bit all_max, bit noise);
        int ew, eh, r, nd;
        ew = eff_width();
        eh = eff_height();
        r = m_radius;
        nd = ew * ((r < eh - 1) ? r : eh - 1);
        if (noise) queue_req(OP_DRAIN, 16'($urandom_range(0, 65535)));
        for (int i = 0; i < ew * eh; i++) queue_req(OP_PIXEL, all_max ? 16'hFFFF : rand_sample());
        for (int i = 0; i < nd; i++) begin
            queue_req(OP_DRAIN, 16'($urandom_range(0, 65535)));
            if (noise && i == 0 && nd > 1) queue_req(OP_PIXEL, rand_sample());
        end
        return ew * eh + nd;
    endfunction

    function automatic logic [63:0] rand_coefs();
        logic [63:0] v;
        if ($urandom_range(3) == 0) return {$urandom, $urandom};
        for (int k = 0; k < 4; k++) v[16*k +: 16] = 16'($urandom_range(0, 12000));
        return v;
    endfunction

    initial begin
        int done;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: one pixel image
        void'(queue_frame(1'b1, 1'b0));
        configure(3, 3, 1, 64'h0000_0000_2000_4000, 64'h0);
        void'(queue_frame(1'b0, 1'b1));
        // saturation
        configure(2, 2, 7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        void'(queue_frame(1'b1, 1'b0));
        // zero sizes act as one
        configure(0, 0, 3, 64'h1000_2000_3000_4000, 64'h0100_0200_0400_0800);
        void'(queue_frame(1'b0, 1'b1));

        // size change in mid-frame: positions beyond the image
        configure(8, 6, 2, 64'h0000_1000_2000_4000, 64'h0);
        for (int i = 0; i < 21; i++) queue_req(OP_PIXEL, rand_sample());
        wait_idle();
        reg_write(REG_WIDTH, 64'd4);
        reg_write(REG_HEIGHT, 64'd2);
        queue_req(OP_PIXEL, rand_sample());
        for (int i = 0; i < 4; i++) queue_req(OP_DRAIN, 16'h0);

        // widest setting, receiver holds off while the block fills, row cut short
        configure(2047, 1, 7, 64'h1111_2222_3333_4444, 64'h0400_0800_0C00_1000);
        for (int i = 0; i < 60; i++) queue_req(OP_PIXEL, rand_sample());
        rx_hold_req = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold_req = 1'b0;
        wait_idle();
        reg_write(REG_WIDTH, 64'd61);
        queue_req(OP_PIXEL, rand_sample());

        // tallest setting, no idling on either side, frame cut short
        configure(1, 8191, 7, 64'h0800_1000_1800_2000, 64'h0100_0200_0300_0400);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 30; i++) queue_req(OP_PIXEL, rand_sample());
        wait_idle();
        reg_write(REG_HEIGHT, 64'd31);
        queue_req(OP_PIXEL, rand_sample());
        for (int i = 0; i < 7; i++) queue_req(OP_DRAIN, 16'h0);
        wait_idle();
        tx_idle_pct = 9;
        rx_idle_pct = 9;

        done = 0;
        while (done < 280) begin
            configure($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7),
                      rand_coefs(), rand_coefs());
            done += queue_frame(1'b0, $urandom_range(3) == 0);
        end
        wait_idle();

        if (err_cnt == 0 && blur_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sgb_pkg.sv
rtl/sgb_if.sv
rtl/sgb_ram.sv
rtl/sgb_cfg.sv
rtl/sgb_mac.sv
rtl/separable_gaussian_blur_unit.sv
rtl/sgb_checker.sv
dv/tb_separable_gaussian_blur_unit.sv
